// ===== rtl/core/load_store_multiple_sequencer_defines.svh =====
// assertion macros for the load/store multiple sequencer
`ifndef LOAD_STORE_MULTIPLE_SEQUENCER_DEFINES_SVH
`define LOAD_STORE_MULTIPLE_SEQUENCER_DEFINES_SVH

`ifndef SYNTHESIS
`define LSMS_ASSERT_HOLD(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("lsms check failed");
`define LSMS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lsms sequence check failed");
`else
`define LSMS_ASSERT_HOLD(label, expr)
`define LSMS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== rtl/core/lsm_pkg.sv =====
// types, field positions and helpers for the load/store multiple sequencer
package lsm_pkg;

  localparam int unsigned LIST_W  = 16;
  localparam int unsigned REG_W   = 4;
  localparam int unsigned CNT_W   = 5;
  localparam int unsigned SPAN_W  = CNT_W + 2;
  localparam int unsigned P_BIT   = 24;
  localparam int unsigned U_BIT   = 23;
  localparam int unsigned W_BIT   = 21;
  localparam int unsigned L_BIT   = 20;
  localparam int unsigned RN_LSB  = 16;
  localparam logic [31:0] WORD_STEP = 32'd4;

  typedef struct packed {
    logic [31:0] instruction;
    logic [31:0] base_value;
  } lsm_in_t;

  typedef struct packed {
    logic             transfer_valid;
    logic [31:0]      address;
    logic [REG_W-1:0] reg_number;
    logic             is_load;
    logic             writeback_enable;
    logic [REG_W-1:0] writeback_reg;
    logic [31:0]      writeback_value;
    logic             last;
  } lsm_out_t;

  typedef struct packed {
    logic [REG_W-1:0]  idx;
    logic [LIST_W-1:0] rest;
    logic              last;
  } pick_t;

  function automatic logic [CNT_W-1:0] popcount(input logic [LIST_W-1:0] list);
    logic [CNT_W-1:0] cnt;
    cnt = '0;
    for (int i = 0; i < LIST_W; i++) begin
      cnt = cnt + CNT_W'(list[i]);
    end
    return cnt;
  endfunction

endpackage

// ===== rtl/core/lsm_pick.sv =====
// lowest set register of the remaining list and the list without it
module lsm_pick (
  input  logic [lsm_pkg::LIST_W-1:0] list,
  output lsm_pkg::pick_t             pick
);
  import lsm_pkg::*;

  logic [REG_W-1:0] idx;

  always_comb begin
    idx = '0;
    for (int i = LIST_W - 1; i >= 0; i--) begin
      if (list[i]) begin
        idx = REG_W'(i);
      end
    end
  end

  assign pick.idx  = idx;
  assign pick.rest = list & (list - LIST_W'(1));
  assign pick.last = (pick.rest == '0);

endmodule

// ===== rtl/core/load_store_multiple_sequencer.sv =====
// load/store multiple sequencer: one word per register of the list, one
// non-transfer word for an empty list; accept, then setup states S_SPAN and
// S_START on the shared 32-bit adder, then one word and one address step per cycle
// while the output is not stalled; new requests stall until the last word is taken
// rst is synchronous: sequencer to idle and output word dropped
module load_store_multiple_sequencer (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  lsm_pkg::lsm_in_t  req,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output lsm_pkg::lsm_out_t rsp
);
  import lsm_pkg::*;
  `include "load_store_multiple_sequencer_defines.svh"

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SPAN  = 4'b0010,
    S_START = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

  state_t state, state_next;

  logic              p, u, w, l;
  logic [REG_W-1:0]  rn;
  logic [LIST_W-1:0] list;
  logic [31:0]       base;
  logic [31:0]       wb_value;
  logic [31:0]       addr;

  logic [31:0]       op_a, op_b, sum;
  logic              op_sub;
  logic [SPAN_W-1:0] span;
  pick_t             pick;
  logic              take;
  lsm_out_t          word;

  lsm_pick u_pick (
    .list (list),
    .pick (pick)
  );

  assign span = {popcount(list), 2'b00};

  // shared adder
  always_comb begin
    op_a   = addr;
    op_b   = WORD_STEP;
    op_sub = 1'b0;
    unique case (state)
      S_SPAN: begin
        op_a   = base;
        op_b   = 32'(span);
        op_sub = !u;
      end
      S_START: begin
        op_a = u ? base : wb_value;
        op_b = (u == p) ? WORD_STEP : '0;
      end
      default: begin
        op_a = addr;
        op_b = WORD_STEP;
      end
    endcase
  end

  assign sum = op_sub ? (op_a - op_b) : (op_a + op_b);

  assign req_stall = (state != S_IDLE);
  assign take      = (state == S_EMIT) && (!rsp_valid || !rsp_stall);

  always_comb begin
    word.transfer_valid   = (list != '0);
    word.address          = (list != '0) ? addr : '0;
    word.reg_number       = (list != '0) ? pick.idx : '0;
    word.is_load          = l;
    word.writeback_enable = w && ((list == '0) || pick.last);
    word.writeback_reg    = rn;
    word.writeback_value  = wb_value;
    word.last             = (list == '0) || pick.last;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (req_valid) state_next = S_SPAN;
      S_SPAN:  state_next = S_START;
      S_START: state_next = S_EMIT;
      S_EMIT:  if (take && word.last) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (take) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && req_valid) begin
      p    <= req.instruction[P_BIT];
      u    <= req.instruction[U_BIT];
      w    <= req.instruction[W_BIT];
      l    <= req.instruction[L_BIT];
      rn   <= req.instruction[RN_LSB +: REG_W];
      list <= req.instruction[LIST_W-1:0];
      base <= req.base_value;
    end
    if (state == S_SPAN) begin
      wb_value <= sum;
    end
    if (state == S_START) begin
      addr <= sum;
    end
    if (take) begin
      rsp <= word;
      if (list != '0) begin
        list <= pick.rest;
        addr <= sum;
      end
    end
  end

  `LSMS_ASSERT_HOLD(a_state_onehot, $onehot(state))
  `LSMS_ASSERT_NEXT(a_accept_busy, req_valid && !req_stall, req_stall && state == S_SPAN)
  `LSMS_ASSERT_NEXT(a_more_follow,
    rsp_valid && !rsp_stall && rsp.transfer_valid && !rsp.last, rsp_valid)
  `LSMS_ASSERT_HOLD(a_empty_word,
    !rsp_valid || rsp.transfer_valid || (rsp.last && rsp.address == '0))
  `LSMS_ASSERT_HOLD(a_wb_on_last, !rsp_valid || !rsp.writeback_enable || rsp.last)

endmodule
